FILE: rtl/upk_pkg.sv
// shared types, constants and byte placement tables for the 24-bit block unpacker
package upk_pkg;

	localparam int MAX_CHANNELS_DEF = 4;
	localparam int BLOCK_BYTES      = 32;
	localparam int SAMPLES_PER_BLK  = 10;
	localparam int ROW_W            = 4;
	localparam int OFS_W            = 5;
	localparam int SAMPLE_W         = 24;
	localparam int CFG_INDEX_W      = 2;
	localparam int CFG_DATA_W       = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FILE_BIG_ENDIAN = 2'd1;

	localparam logic [ROW_W-1:0] LAST_SAMPLE = ROW_W'(SAMPLES_PER_BLK - 1);

	// byte lane (offset mod 3) of each offset within a channel block
	localparam logic [1:0] LANE_OF [BLOCK_BYTES] = '{
		2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
		2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
		2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
		2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1
	};

	// sample row (offset div 3) of each offset within a channel block
	localparam logic [ROW_W-1:0] ROW_OF [BLOCK_BYTES] = '{
		4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2,
		4'd2, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd5,
		4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd7,
		4'd8, 4'd8, 4'd8, 4'd9, 4'd9, 4'd9, 4'd10, 4'd10
	};

	typedef struct packed {
		logic             en;
		logic [1:0]       lane;
		logic [ROW_W-1:0] row;
		logic [7:0]       data;
	} store_wr_t;

endpackage

FILE: rtl/upk_store.sv
// double-banked sample store split into three byte lanes, one sample read per cycle while rd_en is high
module upk_store #(
	parameter int MAX_CHANNELS = upk_pkg::MAX_CHANNELS_DEF
) (
	input  logic                                             clk,
	input  upk_pkg::store_wr_t                               wr,
	input  logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1):0] wr_sel,
	input  logic                                             rd_en,
	input  logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1):0] rd_sel,
	input  logic [upk_pkg::ROW_W-1:0]                        rd_row,
	output logic [upk_pkg::SAMPLE_W-1:0]                     rd_data
);
	import upk_pkg::*;

	localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int AW    = 1 + CHW + ROW_W;
	localparam int DEPTH = 1 << AW;

	logic [7:0] lane0_mem [DEPTH];
	logic [7:0] lane1_mem [DEPTH];
	logic [7:0] lane2_mem [DEPTH];
	logic [SAMPLE_W-1:0] rd_data_q;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	assign wr_addr = {wr_sel, wr.row};
	assign rd_addr = {rd_sel, rd_row};

	always_ff @(posedge clk) begin
		if (wr.en && wr.lane == 2'd0) begin
			lane0_mem[wr_addr] <= wr.data;
		end
		if (wr.en && wr.lane == 2'd1) begin
			lane1_mem[wr_addr] <= wr.data;
		end
		if (wr.en && wr.lane == 2'd2) begin
			lane2_mem[wr_addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= {lane2_mem[rd_addr], lane1_mem[rd_addr], lane0_mem[rd_addr]};
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/upk_queue.sv
// two-entry queue of filled-bank descriptors between front and back
module upk_queue #(
	parameter int W = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic         head_valid,
	output logic [W-1:0] head_data,
	output logic         full
);
	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign head_valid = (count_q != 2'd0);
	assign head_data  = entry_q[rd_ptr_q];
	assign full       = (count_q == 2'd2);

endmodule

FILE: rtl/upk_front.sv
// byte intake: configuration registers, store placement and block completion
module upk_front #(
	parameter int MAX_CHANNELS = upk_pkg::MAX_CHANNELS_DEF
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 s_axis_tvalid,
	output logic                                                 s_axis_tready,
	input  logic [7:0]                                           s_axis_tdata,
	input  logic                                                 cfg_valid,
	input  logic [upk_pkg::CFG_INDEX_W-1:0]                      cfg_index,
	input  logic [upk_pkg::CFG_DATA_W-1:0]                       cfg_data,
	input  logic                                                 queue_full,
	output upk_pkg::store_wr_t                                   wr,
	output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1):0] wr_sel,
	output logic                                                 push,
	output logic                                                 push_bank,
	output logic [$clog2(MAX_CHANNELS + 1)-1:0]                  push_chans
);
	import upk_pkg::*;

	localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNW = $clog2(MAX_CHANNELS + 1);
	localparam int PW  = OFS_W + CHW;

	logic [CFG_DATA_W-1:0] chan_count_q;
	logic                  big_endian_q;
	logic [PW-1:0]         pos_q;
	logic                  bank_q;
	logic [CNW-1:0]        chans;
	logic [PW-1:0]         slot;
	logic [PW:0]           size;
	logic [PW:0]           next_pos;
	logic                  accept;
	logic                  done;

	always_comb begin
		if (chan_count_q == '0) begin
			chans = CNW'(1);
		end else if (chan_count_q > CFG_DATA_W'(MAX_CHANNELS)) begin
			chans = CNW'(MAX_CHANNELS);
		end else begin
			chans = CNW'(chan_count_q);
		end
	end

	assign s_axis_tready = !queue_full;
	assign accept        = s_axis_tvalid && !queue_full;
	assign slot          = pos_q ^ {{(PW-2){1'b0}}, {2{big_endian_q}}};
	assign size          = (PW+1)'(chans) << OFS_W;
	assign next_pos      = {1'b0, pos_q} + (PW+1)'(1);
	assign done          = (next_pos >= size);

	assign wr.en   = accept;
	assign wr.lane = LANE_OF[slot[OFS_W-1:0]];
	assign wr.row  = ROW_OF[slot[OFS_W-1:0]];
	assign wr.data = s_axis_tdata;
	assign wr_sel  = {bank_q, slot[PW-1:OFS_W]};

	assign push       = accept && done;
	assign push_bank  = bank_q;
	assign push_chans = chans;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_count_q <= CFG_DATA_W'(1);
			big_endian_q <= 1'b1;
			pos_q        <= '0;
			bank_q       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_CHANNEL_COUNT: begin
						chan_count_q <= cfg_data;
					end
					REG_FILE_BIG_ENDIAN: begin
						big_endian_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
			if (accept) begin
				if (done) begin
					pos_q  <= '0;
					bank_q <= ~bank_q;
				end else begin
					pos_q <= next_pos[PW-1:0];
				end
			end
		end
	end

endmodule

FILE: rtl/upk_back.sv
// sample emission: walks a filled bank in channel-interleaved order into the output register
module upk_back #(
	parameter int MAX_CHANNELS = upk_pkg::MAX_CHANNELS_DEF
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 head_valid,
	input  logic                                                 head_bank,
	input  logic [$clog2(MAX_CHANNELS + 1)-1:0]                  head_chans,
	output logic                                                 pop,
	output logic                                                 rd_en,
	output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1):0] rd_sel,
	output logic [upk_pkg::ROW_W-1:0]                            rd_row,
	input  logic [upk_pkg::SAMPLE_W-1:0]                         rd_data,
	output logic                                                 m_axis_tvalid,
	input  logic                                                 m_axis_tready,
	output logic [upk_pkg::SAMPLE_W-1:0]                         m_axis_tdata,
	output logic [1:0]                                           m_axis_tuser,
	output logic                                                 m_axis_tlast
);
	import upk_pkg::*;

	localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNW = $clog2(MAX_CHANNELS + 1);
	localparam int CW  = CNW + 1;

	logic [ROW_W-1:0]    sample_q;
	logic [CHW-1:0]      chan_q;
	logic                valid_s1;
	logic [CHW-1:0]      chan_s1;
	logic                last_s1;
	logic                m_valid_q;
	logic [SAMPLE_W-1:0] m_data_q;
	logic [1:0]          m_user_q;
	logic                m_last_q;
	logic                advance;
	logic                issue;
	logic                chan_wrap;
	logic                block_end;

	assign advance   = valid_s1 && (!m_valid_q || m_axis_tready);
	assign issue     = head_valid && (!valid_s1 || advance);
	assign chan_wrap = ((CW'(chan_q) + CW'(1)) == CW'(head_chans));
	assign block_end = chan_wrap && (sample_q == LAST_SAMPLE);

	assign pop    = issue && block_end;
	assign rd_en  = issue;
	assign rd_sel = {head_bank, chan_q};
	assign rd_row = sample_q;

	always_ff @(posedge clk) begin
		if (issue) begin
			chan_s1 <= chan_q;
			last_s1 <= block_end;
		end
		if (advance) begin
			m_data_q <= rd_data;
			m_user_q <= 2'(chan_s1);
			m_last_q <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q  <= '0;
			chan_q    <= '0;
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				if (block_end) begin
					sample_q <= '0;
					chan_q   <= '0;
				end else if (chan_wrap) begin
					sample_q <= sample_q + ROW_W'(1);
					chan_q   <= '0;
				end else begin
					chan_q <= chan_q + CHW'(1);
				end
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

endmodule

FILE: rtl/packed_24bit_block_unpacker_top.sv
// top level of the packed 24-bit block unpacker
// s_axis carries one raw file byte per transfer; bytes fill a block of 32 bytes per
// channel, channel 0 first, each 4-byte word reversed when file_big_endian is set.
// when the block is full, m_axis delivers ten samples per channel, channel-interleaved,
// tuser carries the channel number and tlast marks the final sample of the block.
// cfg writes register 0 (channel_count) or 1 (file_big_endian); cfg_ready is always high.
// throughput: one byte per cycle in and one sample per cycle out, each while that side's
// tready is high; two store banks let a block fill while the previous one drains. a
// block's first sample follows its last byte via the queue, store read and output
// registers. if the receiver stalls until both banks hold unsent blocks, s_axis_tready
// drops until the cycle after the older block's last sample is read from the store.
// reset clears the fill position, bank select and output valid, and sets channel_count
// to 1 and file_big_endian to 1; the store itself holds no reset value.
module packed_24bit_block_unpacker_top #(
	parameter int MAX_CHANNELS = upk_pkg::MAX_CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // data_byte
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [upk_pkg::SAMPLE_W-1:0]    m_axis_tdata,  // sample_value
	output logic [1:0]                      m_axis_tuser,  // channel_index
	output logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [upk_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [upk_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import upk_pkg::*;

	localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNW = $clog2(MAX_CHANNELS + 1);

	store_wr_t           wr;
	logic [CHW:0]        wr_sel;
	logic                push;
	logic                push_bank;
	logic [CNW-1:0]      push_chans;
	logic                pop;
	logic                head_valid;
	logic                head_bank;
	logic [CNW-1:0]      head_chans;
	logic                queue_full;
	logic                rd_en;
	logic [CHW:0]        rd_sel;
	logic [ROW_W-1:0]    rd_row;
	logic [SAMPLE_W-1:0] rd_data;

	assign cfg_ready = 1'b1;

	upk_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.queue_full    (queue_full),
		.wr            (wr),
		.wr_sel        (wr_sel),
		.push          (push),
		.push_bank     (push_bank),
		.push_chans    (push_chans)
	);

	upk_queue #(.W(1 + CNW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({push_bank, push_chans}),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  ({head_bank, head_chans}),
		.full       (queue_full)
	);

	upk_store #(.MAX_CHANNELS(MAX_CHANNELS)) u_store (
		.clk     (clk),
		.wr      (wr),
		.wr_sel  (wr_sel),
		.rd_en   (rd_en),
		.rd_sel  (rd_sel),
		.rd_row  (rd_row),
		.rd_data (rd_data)
	);

	upk_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_bank     (head_bank),
		.head_chans    (head_chans),
		.pop           (pop),
		.rd_en         (rd_en),
		.rd_sel        (rd_sel),
		.rd_row        (rd_row),
		.rd_data       (rd_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
